/* hw/rtl/ttcw_pkg.sv */
// Shared types and constants for the text terminal cell writer.
`default_nettype none

package ttcw_pkg;

  // Fixed widths of the result fields
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int POS_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int CELL_W    = 16;

  // Signed working width for cursor arithmetic: covers targets of -128..127 plus a step
  localparam int CUR_SW = 9;

  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam int                TAB_STEP     = 4;

  // Register index carried on paddr[2]
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACKSPACE,
    OP_PRINT,
    OP_SET,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  char_code;
    logic signed [7:0]  col;
    logic signed [7:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [POS_W-1:0]     cursor_position;
    logic [CHAR_W-1:0]    read_char;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/ttcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ttcw_fifo.sv */
// Two-entry register queue used on both sides of the executor.
`default_nettype none

module ttcw_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ttcw_front.sv */
// Front end: takes requests, classifies them and queues commands for the executor.
`default_nettype none

module ttcw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             hold,
  input  logic [1:0]       req_type,
  input  logic [7:0]       char_code,
  input  logic signed [7:0] target_col,
  input  logic signed [7:0] target_row,
  output logic             full,
  output logic             cmd_valid,
  output ttcw_pkg::cmd_t   cmd,
  input  logic             cmd_pop
);
  import ttcw_pkg::*;

  cmd_t cmd_in;
  logic q_full;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_dout;

  always_comb begin
    cmd_in.char_code = char_code;
    cmd_in.col       = target_col;
    cmd_in.row       = target_row;
    cmd_in.op        = OP_PRINT;
    unique case (req_type)
      REQ_PUT: begin
        unique case (char_code)
          CH_NEWLINE:   cmd_in.op = OP_NEWLINE;
          CH_RETURN:    cmd_in.op = OP_RETURN;
          CH_TAB:       cmd_in.op = OP_TAB;
          CH_BACKSPACE: cmd_in.op = OP_BACKSPACE;
          default:      cmd_in.op = OP_PRINT;
        endcase
      end
      REQ_SET:   cmd_in.op = OP_SET;
      REQ_CLEAR: cmd_in.op = OP_CLEAR;
      REQ_READ:  cmd_in.op = OP_READ;
      default:   cmd_in.op = OP_PRINT;
    endcase
  end

  // hold covers the power-up clearing sweep
  assign full      = q_full || hold;
  assign cmd_valid = !q_empty;
  assign cmd       = q_dout;

  ttcw_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

endmodule

`default_nettype wire

/* hw/rtl/ttcw_back.sv */
// Executor: cursor state, cell store and the clear, scroll and reset sweeps.
`default_nettype none

module ttcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     text_color,
  input  logic           cmd_valid,
  input  ttcw_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output ttcw_pkg::res_t res,
  output logic           busy_init
);
  import ttcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int IW    = $clog2(CELLS + COLUMNS + 1);

  localparam logic [AW-1:0] LAST     = AW'(CELLS - 1);
  localparam logic [AW-1:0] KEEP_END = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [IW-1:0] CELLS_I  = IW'(CELLS);
  localparam logic [IW-1:0] AHEAD_I  = IW'(COLUMNS + 1);

  localparam logic signed [CUR_SW-1:0] COLS_S     = CUR_SW'(COLUMNS);
  localparam logic signed [CUR_SW-1:0] ROWS_S     = CUR_SW'(ROWS);
  localparam logic signed [CUR_SW-1:0] COL_LAST_S = CUR_SW'(COLUMNS - 1);
  localparam logic signed [CUR_SW-1:0] ROW_LAST_S = CUR_SW'(ROWS - 1);
  localparam logic signed [CUR_SW-1:0] ONE_S      = CUR_SW'(1);
  localparam logic signed [CUR_SW-1:0] TAB_S      = CUR_SW'(TAB_STEP);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCR_PRIME,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  state_t state;
  logic [AW-1:0] idx;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;

  logic go;
  logic at_origin;
  logic wr_exec;
  logic wr_cur;
  logic rd_ok;
  logic need_scroll;
  logic signed [CUR_SW-1:0] cc, cr, tc, tr;
  logic signed [CUR_SW-1:0] pre_col, pre_row;
  logic signed [CUR_SW-1:0] fix_col, fix_row;
  logic [CW-1:0] exec_col, res_col;
  logic [RW-1:0] exec_row, res_row;
  logic [AW-1:0] exec_addr, rd_addr, res_pos;
  logic [IW-1:0] nxt_rd;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  assign cc        = CUR_SW'(cur_col);
  assign cr        = CUR_SW'(cur_row);
  assign tc        = CUR_SW'(cmd.col);
  assign tr        = CUR_SW'(cmd.row);
  assign at_origin = (cur_col == '0) && (cur_row == '0);
  assign go        = (state == ST_IDLE) && cmd_valid && !res_full;
  assign cmd_pop   = go;
  assign busy_init = (state == ST_INIT);

  // Position before wrap/clamp/scroll
  always_comb begin
    pre_col = cc;
    pre_row = cr;
    wr_exec = 1'b0;
    wr_cur  = 1'b0;
    unique case (cmd.op)
      OP_NEWLINE: begin
        pre_col = '0;
        pre_row = cr + ONE_S;
      end
      OP_RETURN: pre_col = '0;
      OP_TAB:    pre_col = cc + TAB_S;
      OP_BACKSPACE: begin
        if (!at_origin) begin
          wr_exec = 1'b1;
          if (cur_col == '0) begin
            pre_col = COL_LAST_S;
            pre_row = cr - ONE_S;
          end else begin
            pre_col = cc - ONE_S;
          end
        end
      end
      OP_PRINT: begin
        wr_exec = 1'b1;
        wr_cur  = 1'b1;
        pre_col = cc + ONE_S;
      end
      OP_SET: begin
        pre_col = tc;
        pre_row = tr;
      end
      default: ;
    endcase
  end

  // Wrap at line end, step back across a line, clamp at top, scroll at bottom
  always_comb begin
    fix_col     = pre_col;
    fix_row     = pre_row;
    need_scroll = 1'b0;
    if (pre_col >= COLS_S) begin
      fix_col = '0;
      fix_row = pre_row + ONE_S;
    end else if (pre_col[CUR_SW-1]) begin
      fix_col = '0;
      if (!pre_row[CUR_SW-1] && pre_row != '0) begin
        fix_row = pre_row - ONE_S;
        fix_col = COL_LAST_S;
      end
    end
    if (fix_row[CUR_SW-1]) begin
      fix_row = '0;
    end
    if (fix_row >= ROWS_S) begin
      need_scroll = 1'b1;
      fix_row     = ROW_LAST_S;
    end
  end

  assign rd_ok = !tc[CUR_SW-1] && !tr[CUR_SW-1] && (tc < COLS_S) && (tr < ROWS_S);

  assign exec_col  = wr_cur ? cur_col : CW'(fix_col);
  assign exec_row  = wr_cur ? cur_row : RW'(fix_row);
  assign exec_addr = AW'(AW'(exec_row) * COLS_A) + AW'(exec_col);
  assign rd_addr   = AW'(AW'($unsigned(tr)) * COLS_A) + AW'($unsigned(tc));
  assign nxt_rd    = IW'(idx) + AHEAD_I;

  // Results leave from the fixed-up cursor in the issue cycle, else from the registers
  assign res_col = (state == ST_IDLE) ? CW'(fix_col) : cur_col;
  assign res_row = (state == ST_IDLE) ? RW'(fix_row) : cur_row;
  assign res_pos = AW'(AW'(res_row) * COLS_A) + AW'(res_col);

  always_comb begin
    res.cursor_col      = COL_OUT_W'(res_col);
    res.cursor_row      = ROW_OUT_W'(res_row);
    res.cursor_position = POS_W'(res_pos);
    res.read_char       = (state == ST_READ) ? rdata[CHAR_W-1:0] : '0;
  end

  always_comb begin
    we       = 1'b0;
    waddr    = idx;
    wdata    = {text_color, BLANK_CHAR};
    re       = 1'b0;
    raddr    = rd_addr;
    res_push = 1'b0;
    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        wdata = {RESET_COLOR, BLANK_CHAR};
      end
      ST_IDLE: begin
        if (go) begin
          if (wr_exec) begin
            we    = 1'b1;
            waddr = exec_addr;
            wdata = {text_color, (wr_cur ? cmd.char_code : BLANK_CHAR)};
          end
          if (cmd.op == OP_READ && rd_ok) begin
            re = 1'b1;
          end
          res_push = (cmd.op != OP_CLEAR) && !(cmd.op == OP_READ && rd_ok) && !need_scroll;
        end
      end
      ST_READ: res_push = 1'b1;
      ST_SCR_PRIME: begin
        re    = 1'b1;
        raddr = COLS_A;
      end
      ST_SCROLL: begin
        // read runs one row plus one cell ahead of the write
        we    = 1'b1;
        wdata = {text_color, ((idx < KEEP_END) ? rdata[CHAR_W-1:0] : BLANK_CHAR)};
        if (nxt_rd < CELLS_I) begin
          re    = 1'b1;
          raddr = AW'(nxt_rd);
        end
        res_push = (idx == LAST);
      end
      ST_CLEAR: begin
        we       = 1'b1;
        res_push = (idx == LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      idx     <= '0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            cur_col <= CW'(fix_col);
            cur_row <= RW'(fix_row);
            idx     <= '0;
            priority if (cmd.op == OP_CLEAR) begin
              state <= ST_CLEAR;
            end else if (cmd.op == OP_READ && rd_ok) begin
              state <= ST_READ;
            end else if (need_scroll) begin
              state <= ST_SCR_PRIME;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_READ:      state <= ST_IDLE;
        ST_SCR_PRIME: state <= ST_SCROLL;
        ST_INIT, ST_SCROLL, ST_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ttcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/text_terminal_cell_writer.sv */
// Top level of the text terminal cell writer: request queue, executor, result queue, APB.
//
//   channel   direction  handshake                  payload
//   request   in         push / full                req_type char_code target_col target_row
//   result    out        pop / empty                cursor_col cursor_row cursor_position read_char
//   config    in         psel penable pwrite pready paddr pwdata -> prdata (text_color at 0)
//
// Put, set cursor and out-of-range read finish in the issue cycle. An in-range read pushes its
// result after the registered cell store read. Clear sweeps every cell; a put or set that
// scrolls primes the cell store read and then sweeps every cell, one cell store write per cycle.
// After reset a clearing sweep runs with full held high.
// Two-entry queues on each side let requests queue behind a busy executor and results wait
// for pop; the executor stalls only when the result queue is full.
`default_nettype none

module text_terminal_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      req_type,
  input  logic [7:0]                      char_code,
  input  logic signed [7:0]               target_col,
  input  logic signed [7:0]               target_row,
  output logic                            empty,
  input  logic                            pop,
  output logic [ttcw_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [ttcw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [ttcw_pkg::POS_W-1:0]      cursor_position,
  output logic [ttcw_pkg::CHAR_W-1:0]     read_char,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ttcw_pkg::*;

  logic       text_color_wr;
  logic [7:0] text_color;
  logic       busy_init;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;
  logic       res_push;
  logic       res_full;
  res_t       res_in;
  res_t       res_out;
  logic [$bits(res_t)-1:0] res_dout;

  assign pready        = 1'b1;
  assign text_color_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR);
  assign prdata        = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (text_color_wr) begin
      text_color <= pwdata[7:0];
    end
  end

  ttcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .hold       (busy_init),
    .req_type   (req_type),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .full       (full),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  ttcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .busy_init  (busy_init)
  );

  ttcw_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_out         = res_dout;
  assign cursor_col      = res_out.cursor_col;
  assign cursor_row      = res_out.cursor_row;
  assign cursor_position = res_out.cursor_position;
  assign read_char       = res_out.read_char;

  // A result is only produced when the executor reserved room for it
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result transaction pushed into a full result queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("executor took a command from an empty queue");

  a_init_hold: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> full)
    else $error("request side open before the power-up sweep");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cursor_col < COL_OUT_W'(COLUMNS)))
    else $error("cursor column beyond the line end");

endmodule

`default_nettype wire
